@@ design/crc8_word_framer_checker_defines.svh @@
// Assertion macros shared by the CRC-8 word framer and checker modules
`ifndef CRC8_WORD_FRAMER_CHECKER_DEFINES_SVH
`define CRC8_WORD_FRAMER_CHECKER_DEFINES_SVH

// Checked on every rising edge of clk, suspended while rst is high
`define CWFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge of clk, reset cycles included
`define CWFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/cwfc_pkg.sv @@
// Types, constants and the CRC-8 step shared by the word framer and checker
package cwfc_pkg;

  // Request action codes
  localparam logic [1:0] ACT_CMD  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_RX   = 2'd2;

  // CRC-8: polynomial 0x31, initial value 0xFF, MSB first
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Largest word count a read response may carry
  localparam int unsigned MAX_WORDS = 32;

  // Saturation limits of the receive counters
  localparam logic [6:0] TOTAL_MAX = 7'd127;
  localparam logic [5:0] GOOD_MAX  = 6'd63;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Jobs handed from front to back
  typedef enum logic [2:0] {
    OP_CMD,
    OP_DATA,
    OP_WORD,
    OP_STATUS,
    OP_WORD_STATUS
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] data;   // word to send, or received word
    logic [7:0]  aux;    // CRC over the high byte for a data word
    logic        ok;     // received CRC matched
    logic [5:0]  good;   // completion status value
  } job_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [15:0] word_out;
    logic        crc_ok;
    logic [5:0]  good_words;
    logic        last;
  } result_t;

  // One byte through the CRC-8 register
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/cwfc_req_if.sv @@
// Request channel: valid/ready handshake with the input item fields
interface cwfc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] value;
  logic        frame_end;
  logic [5:0]  expected_words;

  modport source (output valid, action, value, frame_end, expected_words, input ready);
  modport sink (input valid, action, value, frame_end, expected_words, output ready);
endinterface

@@ design/cwfc_res_if.sv @@
// Result channel: valid/ready handshake with the result item fields
interface cwfc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic [15:0] word_out;
  logic        crc_ok;
  logic [5:0]  good_words;
  logic        last;

  modport source (output valid, kind, byte_out, word_out, crc_ok, good_words, last,
                  input ready);
  modport sink (input valid, kind, byte_out, word_out, crc_ok, good_words, last,
                output ready);
endinterface

@@ design/cwfc_front.sv @@
// Front: accepts requests, tracks the receive triple and counters, queues jobs
module cwfc_front (
  input  logic             clk,
  input  logic             rst,
  cwfc_req_if.sink         req,
  output logic             push,
  output cwfc_pkg::job_t   push_data,
  input  logic             full
);

  // Position of the next received byte in its triple
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_CRC    = 2'd2;

  logic [1:0] pos, pos_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [7:0] crc_first, crc_first_next;   // CRC after the first byte
  logic [7:0] crc_exp, crc_exp_next;       // CRC expected for the triple
  logic [6:0] byte_total, byte_total_next;
  logic [5:0] good_count, good_count_next;
  logic       error_seen, error_seen_next;

  logic       accept;
  logic       has_word;
  logic       word_ok;
  logic       len_match;
  logic [7:0] lo;
  logic [7:0] three_x;

  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign lo        = req.value[7:0];
  assign three_x   = ({2'b00, req.expected_words} << 1) + {2'b00, req.expected_words};

  // Classify the request, build its job and the next receive state
  always_comb begin
    pos_next         = pos;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    crc_first_next   = crc_first;
    crc_exp_next     = crc_exp;
    byte_total_next  = byte_total;
    good_count_next  = good_count;
    error_seen_next  = error_seen;
    has_word         = 1'b0;
    word_ok          = 1'b0;
    len_match        = 1'b0;
    push_data        = '0;
    push_data.op     = cwfc_pkg::OP_WORD;
    push             = 1'b0;

    case (req.action)
      cwfc_pkg::ACT_CMD: begin
        pos_next        = POS_FIRST;
        byte_total_next = '0;
        good_count_next = '0;
        error_seen_next = 1'b0;
        push_data.op    = cwfc_pkg::OP_CMD;
        push_data.data  = req.value;
        push            = accept;
      end
      cwfc_pkg::ACT_DATA: begin
        push_data.op   = cwfc_pkg::OP_DATA;
        push_data.data = req.value;
        push_data.aux  = cwfc_pkg::crc_byte(cwfc_pkg::CRC_INIT, req.value[15:8]);
        push           = accept;
      end
      cwfc_pkg::ACT_RX: begin
        if (byte_total != cwfc_pkg::TOTAL_MAX) begin
          byte_total_next = byte_total + 7'd1;
        end
        case (pos)
          POS_FIRST: begin
            first_byte_next = lo;
            crc_first_next  = cwfc_pkg::crc_byte(cwfc_pkg::CRC_INIT, lo);
            pos_next        = POS_SECOND;
          end
          POS_SECOND: begin
            second_byte_next = lo;
            crc_exp_next     = cwfc_pkg::crc_byte(crc_first, lo);
            pos_next         = POS_CRC;
          end
          default: begin
            has_word = 1'b1;
            word_ok  = (crc_exp == lo);
            if (!word_ok) begin
              error_seen_next = 1'b1;
            end else if (!error_seen && good_count != cwfc_pkg::GOOD_MAX) begin
              good_count_next = good_count + 6'd1;
            end
            pos_next = POS_FIRST;
          end
        endcase

        // Status counts only when the byte total fits the expected words
        len_match = ({1'b0, req.expected_words} <= 7'(cwfc_pkg::MAX_WORDS))
                 && ({1'b0, byte_total_next} == three_x);
        push_data.data = {first_byte, second_byte};
        push_data.ok   = word_ok;
        push_data.good = len_match ? good_count_next : '0;

        if (req.frame_end) begin
          push_data.op    = has_word ? cwfc_pkg::OP_WORD_STATUS : cwfc_pkg::OP_STATUS;
          pos_next        = POS_FIRST;
          byte_total_next = '0;
          good_count_next = '0;
          error_seen_next = 1'b0;
          push            = accept;
        end else begin
          push_data.op = cwfc_pkg::OP_WORD;
          push         = accept && has_word;
        end
      end
      default: begin
      end
    endcase
  end

  // Receive state updates on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_FIRST;
      byte_total <= '0;
      good_count <= '0;
      error_seen <= 1'b0;
    end else if (accept) begin
      pos         <= pos_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
      crc_first   <= crc_first_next;
      crc_exp     <= crc_exp_next;
      byte_total  <= byte_total_next;
      good_count  <= good_count_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

@@ design/cwfc_queue.sv @@
// Job queue between front and back
`include "crc8_word_framer_checker_defines.svh"

module cwfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cwfc_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output cwfc_pkg::job_t pop_data,
  output logic           empty
);

  localparam int unsigned PTR_W = $clog2(cwfc_pkg::QUEUE_DEPTH);

  cwfc_pkg::job_t entries [cwfc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(cwfc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CWFC_ASSERT(a_no_overflow, push |-> !full, "job pushed into a full queue")
  `CWFC_ASSERT(a_push_visible, (push && !pop) |=> !empty, "pushed job not visible")

endmodule

@@ design/cwfc_back.sv @@
// Back: expands each job into its result items, one per cycle while the output is free
`include "crc8_word_framer_checker_defines.svh"

module cwfc_back (
  input  logic           clk,
  input  logic           rst,
  output logic           pop,
  input  cwfc_pkg::job_t pop_data,
  input  logic           empty,
  cwfc_res_if.source     res
);

  cwfc_pkg::job_t    cur;
  logic              cur_valid;
  logic [1:0]        step;
  cwfc_pkg::result_t out_reg;
  logic              out_valid;

  cwfc_pkg::result_t res_now;
  logic [1:0]        n_res;
  logic              out_free;
  logic              emit;
  logic              finish;

  assign out_free = !out_valid || res.ready;
  assign emit     = cur_valid && out_free;
  assign finish   = emit && (step == n_res - 2'd1);
  assign pop      = !empty && (!cur_valid || finish);

  // Result item for the current job and step
  always_comb begin
    res_now = '0;
    n_res   = 2'd1;
    case (cur.op)
      cwfc_pkg::OP_CMD: begin
        n_res            = 2'd2;
        res_now.kind     = cwfc_pkg::KIND_TX;
        res_now.byte_out = (step == 2'd0) ? cur.data[15:8] : cur.data[7:0];
        res_now.last     = (step != 2'd0);
      end
      cwfc_pkg::OP_DATA: begin
        n_res        = 2'd3;
        res_now.kind = cwfc_pkg::KIND_TX;
        case (step)
          2'd0:    res_now.byte_out = cur.data[15:8];
          2'd1:    res_now.byte_out = cur.data[7:0];
          default: res_now.byte_out = cwfc_pkg::crc_byte(cur.aux, cur.data[7:0]);
        endcase
        res_now.last = (step == 2'd2);
      end
      cwfc_pkg::OP_WORD: begin
        res_now.kind     = cwfc_pkg::KIND_WORD;
        res_now.word_out = cur.data;
        res_now.crc_ok   = cur.ok;
        res_now.last     = 1'b1;
      end
      cwfc_pkg::OP_STATUS: begin
        res_now.kind       = cwfc_pkg::KIND_STATUS;
        res_now.good_words = cur.good;
        res_now.last       = 1'b1;
      end
      cwfc_pkg::OP_WORD_STATUS: begin
        n_res = 2'd2;
        if (step == 2'd0) begin
          res_now.kind     = cwfc_pkg::KIND_WORD;
          res_now.word_out = cur.data;
          res_now.crc_ok   = cur.ok;
        end else begin
          res_now.kind       = cwfc_pkg::KIND_STATUS;
          res_now.good_words = cur.good;
          res_now.last       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Current job and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (pop) begin
      cur       <= pop_data;
      cur_valid <= 1'b1;
      step      <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      step <= step + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      out_reg   <= res_now;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_reg.kind;
  assign res.byte_out   = out_reg.byte_out;
  assign res.word_out   = out_reg.word_out;
  assign res.crc_ok     = out_reg.crc_ok;
  assign res.good_words = out_reg.good_words;
  assign res.last       = out_reg.last;

  `CWFC_ASSERT_ALWAYS(a_reset_idle, rst |=> (!out_valid && !cur_valid), "busy after reset")
  `CWFC_ASSERT(a_burst_follows, (res.valid && res.ready && !res.last) |=> res.valid,
               "gap inside a result burst")
  `CWFC_ASSERT(a_tx_clean,
               (out_valid && out_reg.kind == cwfc_pkg::KIND_TX) |->
               (out_reg.word_out == '0 && out_reg.good_words == '0 && !out_reg.crc_ok),
               "transmit byte carries stray fields")

endmodule

@@ design/crc8_word_framer_checker.sv @@
// Path: request accepted -> queue entry -> back's current job -> output register.
// Throughput: one result per cycle from the output register while res.ready is high;
//   a command gives 2 results, a data word 3, a received byte 0 to 2.
// A four-entry job queue lets requests be taken while results wait to be taken.
// Reset (rst, synchronous): receive counters and triple position cleared,
//   queue and output emptied; no clearing pass is needed.
module crc8_word_framer_checker (
  input  logic       clk,
  input  logic       rst,
  cwfc_req_if.sink   req,
  cwfc_res_if.source res
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  cwfc_pkg::job_t push_data;
  cwfc_pkg::job_t pop_data;

  cwfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cwfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cwfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .res      (res)
  );

endmodule

@@ bench/cwfc_tb_pkg.sv @@
// CRC-8 seal over a two-byte word, shared by the bench stimulus and the checker
`timescale 1ns / 1ps

package cwfc_tb_pkg;

  import cwfc_pkg::CRC_INIT;
  import cwfc_pkg::CRC_POLY;

  // Bit-serial CRC-8 over {hi, lo}, MSB first
  function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] msg;
    logic [7:0]  r;
    logic        fb;
    msg = {hi, lo};
    r   = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = r[7] ^ msg[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

@@ bench/cwfc_checker.sv @@
// Checker for the CRC-8 word framer: predicts results per request and compares them
`timescale 1ns / 1ps

module cwfc_checker (
  input  logic       clk,
  input  logic       rst,
  cwfc_req_if        req,
  cwfc_res_if        res,
  output int         fail_count,
  output int         pending
);

  import cwfc_pkg::*;
  import cwfc_tb_pkg::*;

  // Results still owed by the block, oldest first
  result_t pending_results[$];
  int      errors;

  // Receive-side state of the framer
  logic [1:0] triple_slot;
  logic [7:0] held_hi;
  logic [7:0] held_lo;
  logic [6:0] rx_count;
  logic [5:0] good_run;
  logic       crc_failed;

  function automatic void clear_receive();
    triple_slot = 2'd0;
    held_hi     = 8'h00;
    held_lo     = 8'h00;
    rx_count    = 7'd0;
    good_run    = 6'd0;
    crc_failed  = 1'b0;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [7:0] b,
                                       input logic [15:0] w, input logic ok,
                                       input logic [5:0] g, input logic l);
    result_t r;
    r.kind       = k;
    r.byte_out   = b;
    r.word_out   = w;
    r.crc_ok     = ok;
    r.good_words = g;
    r.last       = l;
    pending_results.push_back(r);
  endfunction

  // Work out the results one accepted request causes
  function automatic void derive_results(input logic [1:0] act, input logic [15:0] val,
                                         input logic fe, input logic [5:0] ew);
    logic [7:0] rx_byte;
    logic       match;
    logic [5:0] status;
    rx_byte = val[7:0];
    case (act)
      ACT_CMD: begin
        // a command opens a new transaction
        clear_receive();
        queue_result(KIND_TX, val[15:8], 16'h0000, 1'b0, 6'd0, 1'b0);
        queue_result(KIND_TX, val[7:0], 16'h0000, 1'b0, 6'd0, 1'b1);
      end
      ACT_DATA: begin
        queue_result(KIND_TX, val[15:8], 16'h0000, 1'b0, 6'd0, 1'b0);
        queue_result(KIND_TX, val[7:0], 16'h0000, 1'b0, 6'd0, 1'b0);
        queue_result(KIND_TX, word_crc(val[15:8], val[7:0]), 16'h0000, 1'b0, 6'd0, 1'b1);
      end
      ACT_RX: begin
        if (rx_count != TOTAL_MAX) rx_count = rx_count + 7'd1;
        case (triple_slot)
          2'd0: begin
            held_hi     = rx_byte;
            triple_slot = 2'd1;
          end
          2'd1: begin
            held_lo     = rx_byte;
            triple_slot = 2'd2;
          end
          default: begin
            match = (word_crc(held_hi, held_lo) == rx_byte);
            if (!match) crc_failed = 1'b1;
            else if (!crc_failed && good_run != GOOD_MAX) good_run = good_run + 6'd1;
            triple_slot = 2'd0;
            queue_result(KIND_WORD, 8'h00, {held_hi, held_lo}, match, 6'd0, !fe);
          end
        endcase
        // frame end closes the response with its status
        if (fe) begin
          status = (ew <= MAX_WORDS && int'(rx_count) == 3 * int'(ew)) ? good_run : 6'd0;
          queue_result(KIND_STATUS, 8'h00, 16'h0000, 1'b0, status, 1'b1);
          clear_receive();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
               $time, res.kind, res.byte_out);
      $display("  word %0h ok %0b good %0d last %0b",
               res.word_out, res.crc_ok, res.good_words, res.last);
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", want.kind, res.kind);
    compare_field("byte_out", want.byte_out, res.byte_out);
    compare_field("word_out", want.word_out, res.word_out);
    compare_field("crc_ok", want.crc_ok, res.crc_ok);
    compare_field("good_words", want.good_words, res.good_words);
    compare_field("last", want.last, res.last);
  endfunction

  // Sample both channels on the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_receive();
      pending_results.delete();
    end else begin
      if (req.valid && req.ready)
        derive_results(req.action, req.value, req.frame_end, req.expected_words);
      if (res.valid && res.ready) check_result();
    end
    fail_count <= errors;
    pending    <= pending_results.size();
  end

endmodule

@@ bench/tb_crc8_word_framer_checker.sv @@
// Top of the CRC-8 word framer bench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_crc8_word_framer_checker;

  import cwfc_pkg::*;
  import cwfc_tb_pkg::*;

  // Action code the block ignores
  localparam logic [1:0] ACT_IDLE = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 40;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    RDY_ALWAYS,
    RDY_PATTERN,
    RDY_RANDOM
  } ready_mode_t;

  logic        clk;
  logic        rst;
  ready_mode_t ready_mode;
  logic        hold_trig;
  int          fail_count;
  int          pending;
  int          sent;
  int          burst_left;
  bit          gaps_on;
  int          cycle_count;

  cwfc_req_if req ();
  cwfc_res_if res ();

  crc8_word_framer_checker uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  cwfc_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result receiver: own stall pattern, plus a long hold-off on each trigger toggle
  initial begin
    logic        hold_seen;
    int          hold_left;
    logic [11:0] ready_pattern;
    hold_seen     = 1'b0;
    hold_left     = 0;
    ready_pattern = 12'b1101_1001_1110;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        hold_seen = hold_trig;
        res.ready <= 1'b0;
      end else begin
        if (hold_trig != hold_seen) begin
          hold_seen = hold_trig;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          res.ready <= 1'b0;
        end else begin
          case (ready_mode)
            RDY_ALWAYS: res.ready <= 1'b1;
            RDY_PATTERN: begin
              ready_pattern = {ready_pattern[10:0], ready_pattern[11]};
              res.ready <= ready_pattern[0];
            end
            default: res.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Offer one request and hold it until taken; bursts end in a random gap
  task automatic send(input logic [1:0] act, input logic [15:0] val, input logic fe,
                      input logic [5:0] ew);
    req.valid          <= 1'b1;
    req.action         <= act;
    req.value          <= val;
    req.frame_end      <= fe;
    req.expected_words <= ew;
    do @(posedge clk); while (!req.ready);
    if (act != ACT_IDLE) sent++;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  // Stop offering and wait until every owed result has arrived
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Received bytes of a read response; the frame ends cut bytes short of the last triple
  task automatic read_response(input int words, input logic [5:0] ew, input int bad_pct,
                               input int cut);
    int         total;
    int         idx;
    logic [7:0] trio [3];
    total = 3 * words - cut;
    idx   = 0;
    for (int w = 0; w < words; w++) begin
      trio[0] = 8'($urandom);
      trio[1] = 8'($urandom);
      trio[2] = word_crc(trio[0], trio[1]);
      if ($urandom_range(1, 100) <= bad_pct) trio[2] ^= 8'($urandom_range(1, 255));
      for (int j = 0; j < 3; j++) begin
        if (idx < total)
          send(ACT_RX, {8'($urandom), trio[j]}, idx == total - 1,
               idx == total - 1 ? ew : 6'($urandom));
        idx++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering data words, then a full drain
  task automatic hold_off_burst(input int n);
    hold_trig <= ~hold_trig;
    gaps_on = 1'b0;
    for (int i = 0; i < n; i++) send(ACT_DATA, 16'($urandom), 1'($urandom), 6'($urandom));
    settle();
  endtask

  initial begin
    int          base;
    int          pick;
    int          words;
    int          cut;
    logic [5:0]  ew;
    bit          mid_hold_done;
    rst                <= 1'b1;
    req.valid          <= 1'b0;
    req.action         <= ACT_CMD;
    req.value          <= 16'h0000;
    req.frame_end      <= 1'b0;
    req.expected_words <= 6'd0;
    ready_mode         <= RDY_PATTERN;
    hold_trig          <= 1'b0;
    sent          = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    mid_hold_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, stray frame ends, ignored action
    send(ACT_CMD, 16'h0000, 1'b0, 6'd0);
    send(ACT_CMD, 16'hFFFF, 1'b1, 6'd63);
    send(ACT_DATA, 16'h0000, 1'b0, 6'd0);
    send(ACT_DATA, 16'hFFFF, 1'b1, 6'd63);
    send(ACT_DATA, 16'hBEEF, 1'b0, 6'd32);
    send(ACT_IDLE, 16'hFFFF, 1'b1, 6'd63);
    // Good word then bad word, frame end on the sixth byte; high value bits set
    send(ACT_CMD, 16'h2100, 1'b0, 6'd2);
    send(ACT_RX, 16'hA5BE, 1'b0, 6'd63);
    send(ACT_RX, 16'hFFEF, 1'b0, 6'd0);
    send(ACT_RX, {8'h5A, word_crc(8'hBE, 8'hEF)}, 1'b0, 6'd0);
    send(ACT_RX, 16'h0000, 1'b0, 6'd0);
    send(ACT_RX, 16'h00FF, 1'b0, 6'd0);
    send(ACT_RX, {8'hC3, ~word_crc(8'h00, 8'hFF)}, 1'b1, 6'd2);
    // Frame end mid-triple, then a lone byte with zero words expected
    send(ACT_RX, 16'h0012, 1'b0, 6'd0);
    send(ACT_RX, 16'h0034, 1'b1, 6'd1);
    send(ACT_RX, 16'h0000, 1'b1, 6'd0);
    // Clean single word, and one with too many words expected
    read_response(1, 6'd1, 0, 0);
    read_response(1, 6'd33, 0, 0);

    // Receiver stalls long enough that the input backs up
    hold_off_burst(16);

    // Largest responses: full count, then 128 bytes with zero words expected,
    // where a wrapped byte total would read as a match
    gaps_on    = 1'b1;
    ready_mode <= RDY_ALWAYS;
    send(ACT_CMD, 16'($urandom), 1'b0, 6'($urandom));
    read_response(32, 6'd32, 0, 0);
    send(ACT_CMD, 16'($urandom), 1'b0, 6'($urandom));
    read_response(43, 6'd0, 0, 1);

    // Random traffic, mostly well-formed read transactions
    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 2));
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        words = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
          7:       ew = 6'(words + 1);
          8:       ew = 6'(words - 1);
          9:       ew = 6'($urandom);
          default: ew = 6'(words);
        endcase
        cut = ($urandom_range(0, 6) < 5) ? 0 : $urandom_range(1, 2);
        send(ACT_CMD, 16'($urandom), 1'($urandom), 6'($urandom));
        read_response(words, ew, 15, cut);
      end else if (pick < 70) begin
        send(ACT_DATA, 16'($urandom), 1'($urandom), 6'($urandom));
      end else if (pick < 80) begin
        send(ACT_CMD, 16'($urandom), 1'($urandom), 6'($urandom));
      end else begin
        send(2'($urandom), 16'($urandom), 1'($urandom), 6'($urandom));
      end
      if (!mid_hold_done && sent >= base + RANDOM_ITEMS / 2) begin
        mid_hold_done = 1'b1;
        hold_off_burst(12);
        gaps_on = 1'b1;
      end
    end

    // Drain and verdict
    ready_mode <= RDY_ALWAYS;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
